// ----- src/mwfr_pkg.sv -----
// Shared types and constants for the moving-window frame rate meter.
// Depends on nothing; the design files other than mwfr_ram refer to it by scoped names, the testbench imports it.
package mwfr_pkg;

	// Window geometry
	localparam int WINDOW  = 64;
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int COUNT_W = $clog2(WINDOW + 1);

	// Field widths
	localparam int TS_W    = 64;
	localparam int FREQ_W  = 32;
	localparam int DUR_W   = 20;
	localparam int RATE_W  = 40;
	localparam int FRAC_W  = 8;
	localparam int SUM_W   = DUR_W + SLOT_W;
	localparam int PROD_W  = FREQ_W + COUNT_W;
	localparam int NUM_W   = PROD_W + FRAC_W;
	localparam int STEP_W  = $clog2(RATE_W);

	// Configuration port
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_FREQ  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_LIMIT = REG_IDX_W'(1);
	localparam logic [FREQ_W-1:0]    FREQ_RESET  = FREQ_W'(1000000000);
	localparam logic [DUR_W-1:0]     LIMIT_RESET = DUR_W'(1000000);

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  limit;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ----- src/moving_window_frame_rate.sv -----
// Sliding-window frame rate meter: ring of frame durations in a RAM, serial divide.
// Sequence: accept, window update (UPDATE), divider start (MUL), 40-step bit-serial
// divide (DIV), output load (OUT); no new timestamp is accepted until that load.
// The duration ring lives in one synchronous RAM read at acceptance, written in the
// UPDATE cycle that follows. Reset clears all control state at once; no clearing pass is run,
// since ring entries at or beyond the fill count are treated as zero.
module moving_window_frame_rate (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mwfr_pkg::ADDR_W-1:0]       paddr,
	input  logic [mwfr_pkg::DATA_W-1:0]       pwdata,
	output logic [mwfr_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mwfr_pkg::TS_W-1:0]         timestamp,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mwfr_pkg::RATE_W-1:0]       rate_q8,
	output logic [mwfr_pkg::COUNT_W-1:0]      frames_in_window,
	output logic                              sample_taken
);

	mwfr_pkg::cfg_t      cfg;
	mwfr_pkg::div_stat_t div_stat;
	mwfr_pkg::state_t    state_q, state_d;

	logic [mwfr_pkg::TS_W-1:0]    ts_q;
	logic [mwfr_pkg::TS_W-1:0]    prev_q;
	logic [mwfr_pkg::SUM_W-1:0]   sum_q;
	logic [mwfr_pkg::SLOT_W-1:0]  slot_q;
	logic [mwfr_pkg::COUNT_W-1:0] fill_q;
	logic                         taken_q;
	logic                         out_valid_q;
	logic [mwfr_pkg::RATE_W-1:0]  rate_q;
	logic [mwfr_pkg::COUNT_W-1:0] count_q;
	logic                         sample_q;

	logic [mwfr_pkg::TS_W-1:0]    dt;
	logic                         take;
	logic                         full;
	logic [mwfr_pkg::DUR_W-1:0]   ram_rdata;
	logic [mwfr_pkg::DUR_W-1:0]   old_dur;
	logic                         ram_we;
	logic [mwfr_pkg::PROD_W-1:0]  prod;
	logic [mwfr_pkg::NUM_W-1:0]   num;
	logic [mwfr_pkg::RATE_W-1:0]  quo;
	logic                         in_acc;
	logic                         out_load;

	mwfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mwfr_ram #(
		.WIDTH (mwfr_pkg::DUR_W),
		.DEPTH (mwfr_pkg::WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (dt[mwfr_pkg::DUR_W-1:0]),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	mwfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == mwfr_pkg::ST_MUL),
		.num    (num),
		.den    (sum_q),
		.quo    (quo),
		.stat   (div_stat)
	);

	// Duration check; slots at or past the fill count were never written
	assign dt      = ts_q - prev_q;
	assign take    = (prev_q != '0) && (dt != '0)
		&& (dt <= mwfr_pkg::TS_W'(cfg.limit));
	assign full    = fill_q == mwfr_pkg::COUNT_W'(mwfr_pkg::WINDOW);
	assign old_dur = full ? ram_rdata : '0;
	assign ram_we  = (state_q == mwfr_pkg::ST_UPDATE) && take;

	// Numerator fill * freq * 256, captured by the divider
	assign prod = mwfr_pkg::PROD_W'(fill_q) * mwfr_pkg::PROD_W'(cfg.freq);
	assign num  = {prod, mwfr_pkg::FRAC_W'(0)};

	assign in_ready = state_q == mwfr_pkg::ST_IDLE;
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == mwfr_pkg::ST_OUT) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mwfr_pkg::ST_IDLE:   if (in_acc) state_d = mwfr_pkg::ST_UPDATE;
			mwfr_pkg::ST_UPDATE: state_d = mwfr_pkg::ST_MUL;
			mwfr_pkg::ST_MUL:    state_d = mwfr_pkg::ST_DIV;
			mwfr_pkg::ST_DIV:    if (div_stat.done) state_d = mwfr_pkg::ST_OUT;
			mwfr_pkg::ST_OUT:    if (out_load) state_d = mwfr_pkg::ST_IDLE;
			default:             state_d = mwfr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the accepted timestamp
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ts_q <= timestamp;
		end
	end

	// Window state: replace the oldest duration, advance slot and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			sum_q   <= '0;
			slot_q  <= '0;
			fill_q  <= '0;
			taken_q <= 1'b0;
		end else if (state_q == mwfr_pkg::ST_UPDATE) begin
			prev_q  <= ts_q;
			taken_q <= take;
			if (take) begin
				sum_q <= sum_q - mwfr_pkg::SUM_W'(old_dur)
					+ mwfr_pkg::SUM_W'(dt[mwfr_pkg::DUR_W-1:0]);
				slot_q <= (slot_q == mwfr_pkg::SLOT_W'(mwfr_pkg::WINDOW - 1))
					? '0 : slot_q + mwfr_pkg::SLOT_W'(1);
				if (!full) begin
					fill_q <= fill_q + mwfr_pkg::COUNT_W'(1);
				end
			end
		end
	end

	// Output register: load when free or being drained, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rate_q   <= (sum_q == '0) ? '0 : quo;
			count_q  <= fill_q;
			sample_q <= taken_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign rate_q8          = rate_q;
	assign frames_in_window = count_q;
	assign sample_taken     = sample_q;

`ifndef NO_ASSERTIONS
	// Fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mwfr_pkg::COUNT_W'(mwfr_pkg::WINDOW))
		else $error("fill count beyond window");
	// Every held duration is nonzero, so an empty sum means an empty window
	a_sum_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_q == '0) == (fill_q == '0))
		else $error("window sum and fill count disagree");
	// Until the ring is full the write slot tracks the fill count
	a_slot_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> slot_q == fill_q[mwfr_pkg::SLOT_W-1:0])
		else $error("write slot out of step with fill count");
	// Divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == mwfr_pkg::ST_DIV)
		else $error("divider result outside divide state");
`endif

endmodule

// ----- src/mwfr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mwfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, then registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/mwfr_cfg.sv -----
// APB-style register file for tick frequency and frame duration limit.
// Depends on mwfr_pkg.
module mwfr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mwfr_pkg::ADDR_W-1:0]    paddr,
	input  logic [mwfr_pkg::DATA_W-1:0]    pwdata,
	output logic [mwfr_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output mwfr_pkg::cfg_t                 cfg
);

	logic [mwfr_pkg::REG_IDX_W-1:0] idx;
	logic                           wr_en;

	assign idx    = paddr[mwfr_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// Capture register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.freq  <= mwfr_pkg::FREQ_RESET;
			cfg.limit <= mwfr_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				mwfr_pkg::REG_FREQ:  cfg.freq  <= pwdata[mwfr_pkg::FREQ_W-1:0];
				mwfr_pkg::REG_LIMIT: cfg.limit <= pwdata[mwfr_pkg::DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			mwfr_pkg::REG_FREQ:  prdata = mwfr_pkg::DATA_W'(cfg.freq);
			mwfr_pkg::REG_LIMIT: prdata = mwfr_pkg::DATA_W'(cfg.limit);
			default:             prdata = '0;
		endcase
	end

endmodule

// ----- src/mwfr_div.sv -----
// Restoring bit-serial divider: one quotient bit per cycle until all RATE_W quotient bits are formed.
// Depends on mwfr_pkg; the quotient is known to fit RATE_W bits.
module mwfr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mwfr_pkg::NUM_W-1:0]    num,
	input  logic [mwfr_pkg::SUM_W-1:0]    den,
	output logic [mwfr_pkg::RATE_W-1:0]   quo,
	output mwfr_pkg::div_stat_t           stat
);

	logic [mwfr_pkg::SUM_W-1:0]  rem_q;
	logic [mwfr_pkg::RATE_W-1:0] quo_q;
	logic [mwfr_pkg::SUM_W-1:0]  den_q;
	logic [mwfr_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [mwfr_pkg::SUM_W:0]    shifted;
	logic [mwfr_pkg::SUM_W:0]    diff;
	logic                        fits;

	// Trial subtract on the shifted partial remainder
	assign shifted = {rem_q, quo_q[mwfr_pkg::RATE_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	// Control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + mwfr_pkg::STEP_W'(1);
				if (step_q == mwfr_pkg::STEP_W'(mwfr_pkg::RATE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: preload upper dividend bits, then shift one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mwfr_pkg::SUM_W'(num[mwfr_pkg::NUM_W-1:mwfr_pkg::RATE_W]);
			quo_q <= num[mwfr_pkg::RATE_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[mwfr_pkg::SUM_W-1:0] : shifted[mwfr_pkg::SUM_W-1:0];
			quo_q <= {quo_q[mwfr_pkg::RATE_W-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

`ifndef NO_ASSERTIONS
	// A done pulse ends a busy period and never overlaps it
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a preceding busy period");
	// Restart only while idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	// Partial remainder stays below the divisor once a step has run
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && $past(busy_q) && den_q != '0 |-> rem_q < den_q)
		else $error("divider remainder out of range");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the moving-window frame rate meter.
// Depends on mwfr_pkg and moving_window_frame_rate; the expected readings come
// from an in-bench model of the duration ring and the rate division.
`timescale 1ns / 1ps

module tb;
	import mwfr_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 60;

	typedef struct {
		logic [RATE_W-1:0]  rate;
		logic [COUNT_W-1:0] frames;
		logic               taken;
	} meter_reading_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BLOCKS
	} stall_mode_t;

	// DUT connections; every DUT input is known from time zero
	logic                clk;
	logic                arst_n    = 1'b0;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [ADDR_W-1:0]   paddr     = '0;
	logic [DATA_W-1:0]   pwdata    = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [TS_W-1:0]     timestamp = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [RATE_W-1:0]   rate_q8;
	logic [COUNT_W-1:0]  frames_in_window;
	logic                sample_taken;

	// Model copy of configuration and window state
	logic [FREQ_W-1:0]   cfg_freq  = FREQ_RESET;
	logic [DUR_W-1:0]    cfg_limit = LIMIT_RESET;
	logic [TS_W-1:0]     prev_ts   = '0;
	logic [DUR_W-1:0]    ring_dur [WINDOW];
	logic [SUM_W-1:0]    ring_sum  = '0;
	logic [SLOT_W-1:0]   ring_slot = '0;
	logic [COUNT_W-1:0]  ring_fill = '0;

	logic [TS_W-1:0]     pending_ts [$];
	meter_reading_t      expected_readings [$];

	int                  errors      = 0;
	int                  n_stamps    = 0;
	int                  n_readings  = 0;
	int                  n_taken     = 0;
	int                  n_settings  = 0;
	int                  idle_cycles = 0;
	int                  gap_left    = 0;
	int                  burst_left  = 1;
	logic [31:0]         rx_cycle    = '0;
	stall_mode_t         rx_mode     = RX_OPEN;

	moving_window_frame_rate uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.timestamp        (timestamp),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.rate_q8          (rate_q8),
		.frames_in_window (frames_in_window),
		.sample_taken     (sample_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the window model by one timestamp and return the reading it gives
	function automatic meter_reading_t meter_step(input logic [TS_W-1:0] ts);
		logic [TS_W-1:0] dt;
		logic [63:0]     num;
		meter_reading_t  r;
		r.taken = 1'b0;
		if (prev_ts != '0) begin
			dt = ts - prev_ts;
			if (dt >= 1 && dt <= TS_W'(cfg_limit)) begin
				ring_sum = ring_sum - ring_dur[ring_slot] + SUM_W'(dt[DUR_W-1:0]);
				ring_dur[ring_slot] = dt[DUR_W-1:0];
				ring_slot = ring_slot + 1'b1;
				if (ring_fill < WINDOW)
					ring_fill = ring_fill + 1'b1;
				r.taken = 1'b1;
			end
		end
		prev_ts = ts;
		if (ring_sum == '0) begin
			r.rate = '0;
		end else begin
			num = (64'(ring_fill) * 64'(cfg_freq)) << FRAC_W;
			r.rate = RATE_W'(num / 64'(ring_sum));
		end
		r.frames = ring_fill;
		return r;
	endfunction

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			timestamp  <= '0;
			gap_left   <= 0;
			burst_left <= 1;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ts.size() > 0) begin
				in_valid  <= 1'b1;
				timestamp <= pending_ts.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern picked at random from four modes whenever the low byte of rx_cycle reaches FF
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle[7:0] == 8'hFF)
			rx_mode <= stall_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= (rx_cycle[1:0] == 2'b00);
			default:   out_ready <= (rx_cycle[4:0] < 5'd12);
		endcase
	end

	// Monitor: check each result transaction, then predict each input transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_readings++;
				if (expected_readings.size() == 0) begin
					$error("unexpected result: rate_q8 %0d frames_in_window %0d sample_taken %0d",
						rate_q8, frames_in_window, sample_taken);
					errors++;
				end else begin
					meter_reading_t exp_r;
					exp_r = expected_readings.pop_front();
					if (rate_q8 !== exp_r.rate) begin
						$error("rate_q8 expected %0d got %0d", exp_r.rate, rate_q8);
						errors++;
					end
					if (frames_in_window !== exp_r.frames) begin
						$error("frames_in_window expected %0d got %0d",
							exp_r.frames, frames_in_window);
						errors++;
					end
					if (sample_taken !== exp_r.taken) begin
						$error("sample_taken expected %0d got %0d", exp_r.taken, sample_taken);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				meter_reading_t r;
				r = meter_step(timestamp);
				if (r.taken)
					n_taken++;
				n_stamps++;
				expected_readings.push_back(r);
			end
		end
	end

	// Watchdog: count cycles in which no transaction of any kind completes
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Register write: setup cycle, then access cycle until pready
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_FREQ)
			cfg_freq = value[FREQ_W-1:0];
		else if (idx == REG_LIMIT)
			cfg_limit = value[DUR_W-1:0];
		n_settings++;
	endtask

	// Register read with compare against the model copy
	task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
		logic [DATA_W-1:0] exp_v;
		exp_v = (idx == REG_FREQ) ? DATA_W'(cfg_freq) : DATA_W'(cfg_limit);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== exp_v) begin
			$error("prdata[%0d] expected %0h got %0h", idx, exp_v, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Pick a duration mostly inside the current limit, with both edges favored
	function automatic logic [TS_W-1:0] pick_duration();
		int sel;
		sel = $urandom_range(0, 7);
		if (cfg_limit == '0)
			return TS_W'($urandom_range(1, 3));
		if (sel == 0)
			return TS_W'(1);
		if (sel == 1)
			return TS_W'(cfg_limit);
		return TS_W'($urandom_range(1, cfg_limit));
	endfunction

	// Queue well-formed frame sequences with random content, mixed with noise
	task automatic queue_frames(input int count);
		logic [TS_W-1:0] t;
		int              kind;
		t = {$urandom, $urandom};
		if (t == '0)
			t = TS_W'(1);
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 80)
				t = t + pick_duration();
			else if (kind < 85)
				t = t;
			else if (kind < 90)
				t = t + TS_W'(cfg_limit) + TS_W'($urandom_range(1, 1000));
			else if (kind < 94)
				t = {$urandom, $urandom};
			else if (kind < 97)
				t = '0;
			else
				t = {TS_W{1'b1}} - TS_W'($urandom_range(0, cfg_limit));
			pending_ts.push_back(t);
		end
	endtask

	// Wait until the sender has run dry and every expected reading has come back
	task automatic drain();
		while (pending_ts.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_setting(input logic [DATA_W-1:0] freq, input logic [DATA_W-1:0] limit,
			input int count);
		reg_write(REG_FREQ, freq);
		reg_write(REG_LIMIT, limit);
		reg_check(REG_FREQ);
		reg_check(REG_LIMIT);
		queue_frames(count);
		drain();
	endtask

	initial begin
		for (int i = 0; i < WINDOW; i++)
			ring_dur[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values read back
		reg_check(REG_FREQ);
		reg_check(REG_LIMIT);

		// Directed: zero timestamp, first store, zero, limit and over-limit durations, wrap
		pending_ts.push_back(64'd0);
		pending_ts.push_back(64'd100);
		pending_ts.push_back(64'd100);
		pending_ts.push_back(64'd101);
		pending_ts.push_back(64'd101 + 64'(LIMIT_RESET));
		pending_ts.push_back(64'd101 + 64'(LIMIT_RESET) * 2 + 64'd1);
		pending_ts.push_back(64'd0);
		pending_ts.push_back(64'd5);
		pending_ts.push_back({TS_W{1'b1}});
		pending_ts.push_back(64'hFFFF_FFFF_FFFF_FFF0);
		pending_ts.push_back(64'h10);
		pending_ts.push_back({TS_W{1'b1}});
		pending_ts.push_back(64'd0);
		pending_ts.push_back(64'd7);
		pending_ts.push_back(64'd8);
		pending_ts.push_back(64'd9);
		pending_ts.push_back(64'hAAAA_AAAA_AAAA_AAAA);
		pending_ts.push_back(64'h5555_5555_5555_5555);
		pending_ts.push_back(64'h5555_5555_5555_5556);
		drain();

		// Extremes, unit settings, zero frequency, zero limit, then random
		run_setting(32'hFFFF_FFFF, 32'h000F_FFFF, 300);
		run_setting(32'd1, 32'd1, 150);
		run_setting(32'd0, 32'd1000, 60);
		run_setting($urandom, 32'd0, 60);
		run_setting($urandom, 32'($urandom_range(1, 5000)), 330);
		run_setting($urandom | 32'h8000_0000, 32'hFFF0_0000 | 32'($urandom_range(1, 20'hFFFFF)),
			400);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_readings.size() != 0) begin
			$error("%0d expected readings never arrived", expected_readings.size());
			errors++;
		end
		$display("Run covered %0d timestamps, %0d readings, %0d durations taken into the window,",
			n_stamps, n_readings, n_taken);
		$display("across %0d register writes including zero and full-scale settings.", n_settings);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
